// File: src/hashed_transposition_table_macros.svh
// ----------------------------------------------------------------------------
// Hashed transposition table: assertion macros
// Implication checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef HASHED_TRANSPOSITION_TABLE_MACROS_SVH
`define HASHED_TRANSPOSITION_TABLE_MACROS_SVH

// same-cycle implication
`define HTT_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HTT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/htt_pkg.sv
// ----------------------------------------------------------------------------
// htt_pkg
// Shared types, field widths, codes and hash constants of the table.
// ----------------------------------------------------------------------------
`default_nettype none

package htt_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 4096;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned KEY_W   = 64;
   localparam int unsigned BIN_W   = 8;
   localparam int unsigned META_W  = 17;
   localparam int unsigned DEPTH_W = 8;
   localparam int unsigned SCORE_W = 22;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned MOVE_W  = 16;
   localparam int unsigned GEN_W   = 16;
   localparam int unsigned HALF_W  = 32;

   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEW_GEN = 2'd2;

   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXACT = 2'd1;

   localparam logic [MOVE_W-1:0] NO_MOVE   = 16'hFFFF;
   localparam logic [GEN_W-1:0]  GEN_RESET = 16'd1;

   // splitmix64 finalizer constants
   localparam logic [KEY_W-1:0] MIX_C0 = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [KEY_W-1:0] MIX_C1 = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [KEY_W-1:0] MIX_C2 = 64'h94D0_49BB_1331_11EB;
   localparam int unsigned MIX_SH1 = 30;
   localparam int unsigned MIX_SH2 = 27;
   localparam int unsigned MIX_SH3 = 31;
   localparam int unsigned ROT_RED  = 21;
   localparam int unsigned ROT_META = 43;

   // key word select of the hash unit
   localparam logic [1:0] WORD_BLUE = 2'd0;
   localparam logic [1:0] WORD_RED  = 2'd1;
   localparam logic [1:0] WORD_META = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]   blue;
      logic [KEY_W-1:0]   red;
      logic [META_W-1:0]  meta;
      logic [SCORE_W-1:0] score;
      logic [MOVE_W-1:0]  move;
      logic [GEN_W-1:0]   gen;
      logic [DEPTH_W-1:0] depth;
      logic [KIND_W-1:0]  kind;
   } entry_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } tbl_ctl_type;

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_ADD,
      HS_MUL0,
      HS_MUL1,
      HS_MUL2,
      HS_MUL3
   } hash_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_DECIDE
   } ctl_state_type;

endpackage

`default_nettype wire

// File: src/htt_hash.sv
// ----------------------------------------------------------------------------
// htt_hash
// Key hash over three words with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_hash #(
   parameter int unsigned IDX_W = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [htt_pkg::KEY_W-1:0] blue,
   input  logic [htt_pkg::KEY_W-1:0] red,
   input  logic [htt_pkg::KEY_W-1:0] meta,
   output logic                      done,
   output logic [IDX_W-1:0]          hash
);
   import htt_pkg::*;

   hash_state_type     state_ff, state_in;
   logic [1:0]         word_ff, word_in;
   logic               pass_ff, pass_in;
   logic               done_ff, done_in;
   logic [KEY_W-1:0]   v_ff, v_in;
   logic [KEY_W-1:0]   acc_ff, acc_in;
   logic [KEY_W-1:0]   prod_ff, prod_in;
   logic [KEY_W-1:0]   h_ff, h_in;

   logic [KEY_W-1:0]   word_val;
   logic [KEY_W-1:0]   opnd;
   logic [KEY_W-1:0]   cst;
   logic [HALF_W-1:0]  mul_a, mul_b;
   logic [KEY_W-1:0]   product;
   logic [KEY_W-1:0]   sum;
   logic [KEY_W-1:0]   fin;
   logic [KEY_W-1:0]   rot;

   always_comb begin
      case (word_ff)
         WORD_BLUE: word_val = blue;
         WORD_RED:  word_val = red;
         default:   word_val = meta;
      endcase
   end

   assign opnd = pass_ff ? (v_ff ^ (v_ff >> MIX_SH2)) : (v_ff ^ (v_ff >> MIX_SH1));
   assign cst  = pass_ff ? MIX_C2 : MIX_C1;

   // partial products of the low 64 bits: lo*lo, lo*hi, hi*lo
   always_comb begin
      case (state_ff)
         HS_MUL0: begin
            mul_a = opnd[HALF_W-1:0];
            mul_b = cst[HALF_W-1:0];
         end
         HS_MUL1: begin
            mul_a = opnd[HALF_W-1:0];
            mul_b = cst[KEY_W-1:HALF_W];
         end
         default: begin
            mul_a = opnd[KEY_W-1:HALF_W];
            mul_b = cst[HALF_W-1:0];
         end
      endcase
   end

   assign product = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   assign sum     = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign fin     = sum ^ (sum >> MIX_SH3);

   always_comb begin
      case (word_ff)
         WORD_BLUE: rot = fin;
         WORD_RED:  rot = (fin << ROT_RED) | (fin >> (KEY_W - ROT_RED));
         default:   rot = (fin << ROT_META) | (fin >> (KEY_W - ROT_META));
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         HS_IDLE: if (start) state_in = HS_ADD;
         HS_ADD:  state_in = HS_MUL0;
         HS_MUL0: state_in = HS_MUL1;
         HS_MUL1: state_in = HS_MUL2;
         HS_MUL2: state_in = HS_MUL3;
         HS_MUL3: begin
            if (!pass_ff) begin
               state_in = HS_MUL0;
            end else if (word_ff == WORD_META) begin
               state_in = HS_IDLE;
            end else begin
               state_in = HS_ADD;
            end
         end
         default: state_in = HS_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      word_in = word_ff;
      pass_in = pass_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      h_in    = h_ff;
      unique case (state_ff)
         HS_IDLE: begin
            if (start) begin
               word_in = WORD_BLUE;
               pass_in = 1'b0;
               h_in    = '0;
            end
         end
         HS_ADD: begin
            v_in    = word_val + MIX_C0;
            pass_in = 1'b0;
         end
         HS_MUL0: prod_in = product;
         HS_MUL1: begin
            acc_in  = prod_ff;
            prod_in = product;
         end
         HS_MUL2: begin
            acc_in  = sum;
            prod_in = product;
         end
         HS_MUL3: begin
            if (!pass_ff) begin
               v_in    = sum;
               pass_in = 1'b1;
            end else begin
               h_in    = h_ff ^ rot;
               word_in = word_ff + 2'd1;
               done_in = (word_ff == WORD_META);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      pass_ff <= pass_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      h_ff    <= h_in;
   end

   assign done = done_ff;
   assign hash = h_ff[IDX_W-1:0];

endmodule

`default_nettype wire

// File: src/htt_table.sv
// ----------------------------------------------------------------------------
// htt_table
// Slot memory with one shared port and a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_table #(
   parameter int unsigned ENTRIES = 4096,
   parameter int unsigned IDX_W   = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  htt_pkg::tbl_ctl_type ctl,
   input  logic [IDX_W-1:0]     addr,
   input  htt_pkg::entry_type   wr_data,
   output htt_pkg::entry_type   rd_data,
   output logic                 busy
);
   import htt_pkg::*;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   entry_type          mem [ENTRIES];
   entry_type          rd_data_ff;
   logic               clearing_ff, clearing_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_word;

   always_comb begin
      clearing_in = clearing_ff;
      cnt_in      = cnt_ff;
      if (clearing_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) clearing_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         cnt_ff      <= '0;
      end else begin
         clearing_ff <= clearing_in;
         cnt_ff      <= cnt_in;
      end
   end

   // an all-zero word is an empty slot
   assign wr_en   = clearing_ff | ctl.wr;
   assign wr_addr = clearing_ff ? cnt_ff : addr;
   assign wr_word = clearing_ff ? entry_type'('0) : wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_word;
      if (ctl.rd) rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

`default_nettype wire

// File: src/hashed_transposition_table.sv
// ----------------------------------------------------------------------------
// hashed_transposition_table
// Direct-mapped table of search results with depth-preferred replacement.
// ----------------------------------------------------------------------------
// A lookup or store word keeps the input stalled from its acceptance edge
// until the sequencer is idle again, and then the next word can be taken. The
// key hash runs three splitmix64 mixes on a single shared 32x32 multiplier.
// Each mix is an add step and two 64-bit products, each built from three
// partial products. The sequencer then waits for the hash done flag, reads
// the memory, and decides whether to write the slot. A generation bump or
// an unused command does not stall the input. After reset the block stalls
// its input while a clearing pass marks every slot empty. A lookup result
// sits in an output register, and the next word may be accepted while it
// waits. A later lookup that finds that register still stalled holds in its
// decide state until the register drains.
`default_nettype none

`include "hashed_transposition_table_macros.svh"

module hashed_transposition_table #(
   parameter int unsigned ENTRIES = htt_pkg::ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [htt_pkg::CMD_W-1:0]           req_cmd,
   input  logic [htt_pkg::KEY_W-1:0]           req_blue_squares,
   input  logic [htt_pkg::KEY_W-1:0]           req_red_squares,
   input  logic [htt_pkg::BIN_W-1:0]           req_blue_bin_count,
   input  logic [htt_pkg::BIN_W-1:0]           req_red_bin_count,
   input  logic                                req_side_to_move,
   input  logic [htt_pkg::DEPTH_W-1:0]         req_search_depth,
   input  logic signed [htt_pkg::SCORE_W-1:0]  req_result_score,
   input  logic [htt_pkg::KIND_W-1:0]          req_bound_kind,
   input  logic [htt_pkg::MOVE_W-1:0]          req_move_code,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic signed [htt_pkg::SCORE_W-1:0]  rsp_out_score,
   output logic [htt_pkg::MOVE_W-1:0]          rsp_out_move,
   output logic [htt_pkg::DEPTH_W-1:0]         rsp_out_depth,
   output logic [htt_pkg::KIND_W-1:0]          rsp_out_bound
);
   import htt_pkg::*;

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ENTRIES - 1);

   ctl_state_type       state_ff, state_in;

   // captured request word
   logic [CMD_W-1:0]    cmd_ff;
   logic [KEY_W-1:0]    blue_ff;
   logic [KEY_W-1:0]    red_ff;
   logic [META_W-1:0]   meta_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [SCORE_W-1:0]  score_ff;
   logic [KIND_W-1:0]   bound_ff;
   logic [MOVE_W-1:0]   move_ff;

   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [SCORE_W-1:0]  rsp_score_ff;
   logic [MOVE_W-1:0]   rsp_move_ff;
   logic [DEPTH_W-1:0]  rsp_depth_ff;
   logic [KIND_W-1:0]   rsp_bound_ff;

   logic                accept;
   logic                is_access;
   logic                hash_start;
   logic                hash_done;
   logic [IDX_W-1:0]    hash_idx;
   tbl_ctl_type         tbl_ctl;
   entry_type           slot;
   entry_type           new_entry;
   logic                table_busy;

   logic                slot_valid;
   logic                same_key;
   logic                skip_store;
   logic                out_free;
   logic                rsp_load;

   assign accept    = req_valid && !req_stall;
   assign is_access = (req_cmd == CMD_LOOKUP) || (req_cmd == CMD_STORE);

   // ---------------------------------------------------------------------
   // Hash unit: started on the acceptance edge, works on the captured key,
   // pulses done with the index
   // ---------------------------------------------------------------------
   htt_hash #(
      .IDX_W (IDX_W)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .blue  (blue_ff),
      .red   (red_ff),
      .meta  ({{(KEY_W - META_W){1'b0}}, meta_ff}),
      .done  (hash_done),
      .hash  (hash_idx)
   );

   // ---------------------------------------------------------------------
   // Slot memory
   // ---------------------------------------------------------------------
   assign new_entry = '{
      blue:  blue_ff,
      red:   red_ff,
      meta:  meta_ff,
      score: score_ff,
      move:  move_ff,
      gen:   gen_ff,
      depth: depth_ff,
      kind:  bound_ff
   };

   htt_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .addr    (idx_ff),
      .wr_data (new_entry),
      .rd_data (slot),
      .busy    (table_busy)
   );

   // ---------------------------------------------------------------------
   // Replacement decision on the slot read back
   // ---------------------------------------------------------------------
   assign slot_valid = (slot.kind != KIND_EMPTY);
   assign same_key   = slot_valid && (slot.blue == blue_ff) && (slot.red == red_ff)
                       && (slot.meta == meta_ff);

   // Protect a deeper entry of another key from this generation, and a deeper
   // exact entry of the same key against a non-exact bound.
   assign skip_store = (!same_key && slot_valid && (slot.gen == gen_ff)
                        && (slot.depth > depth_ff))
                    || (same_key && (slot.depth > depth_ff)
                        && (slot.kind == KIND_EXACT) && (bound_ff != KIND_EXACT));

   // the response register frees up when it is empty or drains this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && is_access) state_in = ST_HASH;
         ST_HASH:   if (hash_done) state_in = ST_READ;
         ST_READ:   state_in = ST_DECIDE;
         ST_DECIDE: begin
            // hold a lookup until its result can be parked
            if (cmd_ff == CMD_STORE || out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_stall  = 1'b1;
      hash_start = 1'b0;
      tbl_ctl    = '0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = table_busy;
            hash_start = req_valid && !table_busy && is_access;
         end
         ST_HASH: ;
         ST_READ: tbl_ctl.rd = 1'b1;
         ST_DECIDE: begin
            tbl_ctl.wr = (cmd_ff == CMD_STORE) && !skip_store;
            rsp_load   = (cmd_ff == CMD_LOOKUP) && out_free;
         end
         default: ;
      endcase
   end

   // generation bump takes effect on its own acceptance edge
   always_comb begin
      gen_in = gen_ff;
      if (accept) begin
         unique case (req_cmd)
            CMD_NEW_GEN: gen_in = gen_ff + 1'b1;
            default:     gen_in = gen_ff;
         endcase
      end
   end

   assign idx_in       = hash_done ? (hash_idx & IDX_MASK) : idx_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= GEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the request word; payload needs no reset
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         cmd_ff   <= req_cmd;
         blue_ff  <= req_blue_squares;
         red_ff   <= req_red_squares;
         meta_ff  <= {req_side_to_move, req_red_bin_count, req_blue_bin_count};
         depth_ff <= req_search_depth;
         score_ff <= req_result_score;
         bound_ff <= req_bound_kind;
         move_ff  <= req_move_code;
      end
   end

   // a miss answers zeros and the no-move code
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff <= same_key;
         if (same_key) begin
            rsp_score_ff <= slot.score;
            rsp_move_ff  <= slot.move;
            rsp_depth_ff <= slot.depth;
            rsp_bound_ff <= slot.kind;
         end else begin
            rsp_score_ff <= '0;
            rsp_move_ff  <= NO_MOVE;
            rsp_depth_ff <= '0;
            rsp_bound_ff <= KIND_EMPTY;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_out_score = $signed(rsp_score_ff);
   assign rsp_out_move  = rsp_move_ff;
   assign rsp_out_depth = rsp_depth_ff;
   assign rsp_out_bound = rsp_bound_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `HTT_ASSERT_IMPL(a_wr_store_only, tbl_ctl.wr, (cmd_ff == CMD_STORE) && !table_busy, "slot write outside a store")
   `HTT_ASSERT_IMPL(a_done_in_hash, hash_done, state_ff == ST_HASH, "hash done outside hash wait")
   `HTT_ASSERT_IMPL(a_rsp_from_decide, $rose(rsp_valid_ff), $past(state_ff) == ST_DECIDE, "response without a decided lookup")
   `HTT_ASSERT_NEXT(a_load_shows, rsp_load, rsp_valid_ff && (rsp_hit_ff == $past(same_key)), "loaded response lost")

endmodule

`default_nettype wire

// File: tb/tt_lookup_checker.sv
// ----------------------------------------------------------------------------
// Transposition table lookup checker
// Keeps a shadow copy of the slot array, updates it on every accepted store
// and compares each lookup answer with the shadow's prediction.
// ----------------------------------------------------------------------------

package tt_position_pkg;
   import htt_pkg::*;

   localparam int unsigned SLOT_W = $clog2(ENTRIES_DEFAULT);

   localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
   localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UPPER = 2'd3;

   localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

   typedef struct packed {
      logic [KEY_W-1:0] blue;
      logic [KEY_W-1:0] red;
      logic [BIN_W-1:0] blue_count;
      logic [BIN_W-1:0] red_count;
      logic             side;
   } position_type;

   function automatic logic [63:0] splitmix(input logic [63:0] v);
      logic [63:0] x;
      x = v + GOLDEN_GAMMA;
      x = (x ^ (x >> 30)) * MIX_MUL_A;
      x = (x ^ (x >> 27)) * MIX_MUL_B;
      return x ^ (x >> 31);
   endfunction

   function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
      return (v << n) | (v >> (64 - n));
   endfunction

   // slot index: low bits of the combined key hash
   function automatic logic [SLOT_W-1:0] slot_of(input position_type p);
      logic [63:0] h;
      h = splitmix(p.blue) ^ rotl(splitmix(p.red), 21)
        ^ rotl(splitmix({47'd0, p.side, p.red_count, p.blue_count}), 43);
      return h[SLOT_W-1:0];
   endfunction
endpackage

module tt_lookup_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [htt_pkg::CMD_W-1:0]           req_cmd,
   input  logic [htt_pkg::KEY_W-1:0]           req_blue_squares,
   input  logic [htt_pkg::KEY_W-1:0]           req_red_squares,
   input  logic [htt_pkg::BIN_W-1:0]           req_blue_bin_count,
   input  logic [htt_pkg::BIN_W-1:0]           req_red_bin_count,
   input  logic                                req_side_to_move,
   input  logic [htt_pkg::DEPTH_W-1:0]         req_search_depth,
   input  logic signed [htt_pkg::SCORE_W-1:0]  req_result_score,
   input  logic [htt_pkg::KIND_W-1:0]          req_bound_kind,
   input  logic [htt_pkg::MOVE_W-1:0]          req_move_code,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_hit,
   input  logic signed [htt_pkg::SCORE_W-1:0]  rsp_out_score,
   input  logic [htt_pkg::MOVE_W-1:0]          rsp_out_move,
   input  logic [htt_pkg::DEPTH_W-1:0]         rsp_out_depth,
   input  logic [htt_pkg::KIND_W-1:0]          rsp_out_bound,
   output int                                  mismatches,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import htt_pkg::*;
   import tt_position_pkg::*;

   typedef struct packed {
      logic               hit;
      logic [SCORE_W-1:0] score;
      logic [MOVE_W-1:0]  move;
      logic [DEPTH_W-1:0] depth;
      logic [KIND_W-1:0]  bound;
   } answer_type;

   entry_type        slots [ENTRIES_DEFAULT];
   logic [GEN_W-1:0] cur_gen;
   answer_type       answers_due [$];

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: lookup %s mismatch, expected %0h, actual %0h",
                  $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      position_type      pos;
      answer_type        due;
      logic [SLOT_W-1:0] idx;
      logic              occupied;
      logic              same;
      logic              keep_resident;
      if (reset) begin
         foreach (slots[i]) slots[i].kind = KIND_EMPTY;
         cur_gen = GEN_RESET;
         answers_due.delete();
         mismatches = 0;
      end else begin
         // check answers first: an answer never belongs to the word taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: lookup answer with none expected, expected nothing, actual hit %b",
                        $time, rsp_hit);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               compare_field("hit", due.hit, rsp_hit);
               compare_field("score", due.score, $unsigned(rsp_out_score));
               compare_field("move", due.move, rsp_out_move);
               compare_field("depth", due.depth, rsp_out_depth);
               compare_field("bound", due.bound, rsp_out_bound);
            end
         end
         if (req_valid && !req_stall) begin
            pos = {req_blue_squares, req_red_squares, req_blue_bin_count,
                   req_red_bin_count, req_side_to_move};
            case (req_cmd) inside
               CMD_NEW_GEN: cur_gen = cur_gen + 1'b1;
               CMD_LOOKUP, CMD_STORE: begin
                  idx      = slot_of(pos);
                  occupied = slots[idx].kind != KIND_EMPTY;
                  same     = occupied && slots[idx].blue == pos.blue
                             && slots[idx].red == pos.red
                             && slots[idx].meta == {pos.side, pos.red_count, pos.blue_count};
                  if (req_cmd == CMD_LOOKUP) begin
                     due.hit   = same;
                     due.score = same ? slots[idx].score : '0;
                     due.move  = same ? slots[idx].move : NO_MOVE;
                     due.depth = same ? slots[idx].depth : '0;
                     due.bound = same ? slots[idx].kind : KIND_EMPTY;
                     answers_due.insert(answers_due.size(), due);
                  end else begin
                     // deeper resident of this generation, or deeper exact of the same key
                     keep_resident = (!same && occupied && slots[idx].gen == cur_gen
                                      && slots[idx].depth > req_search_depth)
                                  || (same && slots[idx].depth > req_search_depth
                                      && slots[idx].kind == KIND_EXACT
                                      && req_bound_kind != KIND_EXACT);
                     if (!keep_resident) begin
                        slots[idx].blue  = pos.blue;
                        slots[idx].red   = pos.red;
                        slots[idx].meta  = {pos.side, pos.red_count, pos.blue_count};
                        slots[idx].score = req_result_score;
                        slots[idx].move  = req_move_code;
                        slots[idx].gen   = cur_gen;
                        slots[idx].depth = req_search_depth;
                        slots[idx].kind  = req_bound_kind;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      outstanding = answers_due.size();
   end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Hashed transposition table regression
// Drives lookups, stores and generation bumps on pools of colliding keys,
// with random idle and stall bursts; a separate checker predicts answers.
// ----------------------------------------------------------------------------

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import htt_pkg::*;
   import tt_position_pkg::*;

   localparam int RANDOM_WORDS = 330;     // lookups and stores in the random part
   localparam int CALM_WORDS   = 60;      // final stretch without idling
   localparam int GROUPS       = 6;
   localparam int GROUP_SIZE   = 3;       // keys per group, all on one slot
   localparam int POOL_SIZE    = GROUPS * GROUP_SIZE;
   localparam int SETTLE_CYCLES = 64;
   // covers the clearing pass plus every word of the run, with wide margin
   localparam int CYCLE_LIMIT  = 200_000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_cmd;
   logic [KEY_W-1:0]          req_blue_squares;
   logic [KEY_W-1:0]          req_red_squares;
   logic [BIN_W-1:0]          req_blue_bin_count;
   logic [BIN_W-1:0]          req_red_bin_count;
   logic                      req_side_to_move;
   logic [DEPTH_W-1:0]        req_search_depth;
   logic signed [SCORE_W-1:0] req_result_score;
   logic [KIND_W-1:0]         req_bound_kind;
   logic [MOVE_W-1:0]         req_move_code;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_hit;
   logic signed [SCORE_W-1:0] rsp_out_score;
   logic [MOVE_W-1:0]         rsp_out_move;
   logic [DEPTH_W-1:0]        rsp_out_depth;
   logic [KIND_W-1:0]         rsp_out_bound;

   int           mismatches;
   int           outstanding;
   int           cycle_count;
   bit           quiet;        // suppress idling on both sides
   position_type pool [POOL_SIZE];

   hashed_transposition_table DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_blue_squares   (req_blue_squares),
      .req_red_squares    (req_red_squares),
      .req_blue_bin_count (req_blue_bin_count),
      .req_red_bin_count  (req_red_bin_count),
      .req_side_to_move   (req_side_to_move),
      .req_search_depth   (req_search_depth),
      .req_result_score   (req_result_score),
      .req_bound_kind     (req_bound_kind),
      .req_move_code      (req_move_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_out_score      (rsp_out_score),
      .rsp_out_move       (rsp_out_move),
      .rsp_out_depth      (rsp_out_depth),
      .rsp_out_bound      (rsp_out_bound)
   );

   tt_lookup_checker u_lookup_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_blue_squares   (req_blue_squares),
      .req_red_squares    (req_red_squares),
      .req_blue_bin_count (req_blue_bin_count),
      .req_red_bin_count  (req_red_bin_count),
      .req_side_to_move   (req_side_to_move),
      .req_search_depth   (req_search_depth),
      .req_result_score   (req_result_score),
      .req_bound_kind     (req_bound_kind),
      .req_move_code      (req_move_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_out_score      (rsp_out_score),
      .rsp_out_move       (rsp_out_move),
      .rsp_out_depth      (rsp_out_depth),
      .rsp_out_bound      (rsp_out_bound),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up if the run hangs.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("hashed_transposition_table regression: fail");
      $finish;
   end

   // Stall the answer channel in random bursts between free stretches.
   initial begin : answer_stall
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 60)) @(negedge clock);
         if (!quiet) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic position_type random_position();
      position_type p;
      p.blue       = {$urandom, $urandom};
      p.red        = {$urandom, $urandom};
      p.blue_count = 8'($urandom_range(0, 255));
      p.red_count  = 8'($urandom_range(0, 255));
      p.side       = 1'($urandom_range(0, 1));
      return p;
   endfunction

   // Offer one word at the falling edge, maybe after an idle burst, and hold
   // it until the table takes it.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input position_type p,
                            input logic [DEPTH_W-1:0] depth,
                            input logic [SCORE_W-1:0] score,
                            input logic [KIND_W-1:0] bound,
                            input logic [MOVE_W-1:0] move);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_cmd            = cmd;
      req_blue_squares   = p.blue;
      req_red_squares    = p.red;
      req_blue_bin_count = p.blue_count;
      req_red_bin_count  = p.red_count;
      req_side_to_move   = p.side;
      req_search_depth   = depth;
      req_result_score   = score;
      req_bound_kind     = bound;
      req_move_code      = move;
      req_valid          = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold until every lookup answer is in.
   task automatic wait_for_answers();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      position_type      p;
      position_type      corner_lo;
      position_type      corner_hi;
      position_type      key_a;
      position_type      key_b;
      position_type      key_c;
      logic [CMD_W-1:0]  cmd;
      logic [DEPTH_W-1:0] depth;
      logic [SCORE_W-1:0] score;
      logic [KIND_W-1:0] bound;
      logic [MOVE_W-1:0] move;
      int                roll;
      int                table_words;
      bit                paused;

      // drive every input to a known value from time zero
      reset              = 1'b1;
      quiet              = 1'b0;
      req_valid          = 1'b0;
      req_cmd            = CMD_LOOKUP;
      req_blue_squares   = '0;
      req_red_squares    = '0;
      req_blue_bin_count = '0;
      req_red_bin_count  = '0;
      req_side_to_move   = 1'b0;
      req_search_depth   = '0;
      req_result_score   = '0;
      req_bound_kind     = KIND_EMPTY;
      req_move_code      = '0;

      // Build groups of keys that share a slot, so that replacement and
      // protection get exercised; vary the blue mask until the slot matches.
      for (int g = 0; g < GROUPS; g++) begin
         pool[g * GROUP_SIZE] = random_position();
         for (int m = 1; m < GROUP_SIZE; m++) begin
            p = random_position();
            while (slot_of(p) != slot_of(pool[g * GROUP_SIZE])) p.blue = {$urandom, $urandom};
            pool[g * GROUP_SIZE + m] = p;
         end
      end
      key_a     = pool[0];
      key_b     = pool[1];
      key_c     = pool[2];
      corner_lo = '0;
      corner_hi = '1;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part; the first word also waits out the clearing pass.
      // lookup miss on a cleared slot
      send_word(CMD_LOOKUP, corner_lo, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      send_word(CMD_STORE, corner_hi, 8'd255, 22'(2_000_000), KIND_EXACT, 16'h0000);
      send_word(CMD_LOOKUP, corner_hi, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      send_word(CMD_STORE, corner_lo, 8'd0, 22'(-2_000_000), KIND_LOWER, NO_MOVE);
      send_word(CMD_LOOKUP, corner_lo, 8'd255, '1, KIND_UPPER, 16'hFFFF);
      // shallower non-exact bound must not displace a deeper exact entry
      send_word(CMD_STORE, corner_hi, 8'd10, 22'd99, KIND_UPPER, 16'h00FF);
      send_word(CMD_LOOKUP, corner_hi, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      // shallower exact bound replaces it; score above range kept bit for bit
      send_word(CMD_STORE, corner_hi, 8'd10, 22'h1F_FFFF, KIND_EXACT, 16'h1234);
      send_word(CMD_LOOKUP, corner_hi, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      // colliding key protected by a deeper resident of this generation
      send_word(CMD_STORE, key_a, 8'd50, 22'd7, KIND_EXACT, 16'd5);
      send_word(CMD_STORE, key_b, 8'd20, 22'd8, KIND_LOWER, 16'd6);
      send_word(CMD_LOOKUP, key_b, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      send_word(CMD_LOOKUP, key_a, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      // after a bump the old resident yields; score below range
      send_word(CMD_NEW_GEN, corner_lo, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      send_word(CMD_STORE, key_b, 8'd20, 22'h20_0000, KIND_LOWER, 16'hABCD);
      send_word(CMD_LOOKUP, key_a, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      send_word(CMD_LOOKUP, key_b, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      // storing an empty bound empties the slot
      send_word(CMD_STORE, key_b, 8'd3, 22'd1, KIND_EMPTY, 16'd1);
      send_word(CMD_LOOKUP, key_b, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      send_word(CMD_UNUSED, corner_hi, 8'd255, '1, KIND_UPPER, 16'hFFFF);
      send_word(CMD_STORE, key_c, 8'd0, 22'd0, KIND_UPPER, 16'd42);
      send_word(CMD_LOOKUP, key_c, 8'd0, '0, KIND_EMPTY, NO_MOVE);

      // A deep resident of the current generation holds off a shallow collider.
      send_word(CMD_STORE, key_a, 8'd100, 22'd11, KIND_EXACT, 16'd77);
      send_word(CMD_STORE, key_b, 8'd5, 22'd12, KIND_UPPER, 16'd78);
      send_word(CMD_LOOKUP, key_b, 8'd0, '0, KIND_EMPTY, NO_MOVE);
      send_word(CMD_LOOKUP, key_a, 8'd0, '0, KIND_EMPTY, NO_MOVE);

      // Random part: mostly pooled keys so that hits and collisions are common.
      table_words = 0;
      paused      = 1'b0;
      while (table_words < RANDOM_WORDS) begin
         if (!paused && table_words == RANDOM_WORDS / 2) begin
            wait_for_answers();
            paused = 1'b1;
         end
         quiet = table_words >= RANDOM_WORDS - CALM_WORDS;
         p = ($urandom_range(0, 9) != 0) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : random_position();
         roll = $urandom_range(0, 99);
         if (roll < 44) cmd = CMD_LOOKUP;
         else if (roll < 88) cmd = CMD_STORE;
         else if (roll < 95) cmd = CMD_NEW_GEN;
         else cmd = CMD_UNUSED;
         depth = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 15));
         score = ($urandom_range(0, 7) == 0) ? 22'($urandom)
                                              : 22'($urandom_range(0, 4_000_000) - 2_000_000);
         bound = ($urandom_range(0, 9) == 0) ? KIND_EMPTY : 2'($urandom_range(1, 3));
         move  = ($urandom_range(0, 7) == 0) ? NO_MOVE : 16'($urandom);
         send_word(cmd, p, depth, score, bound, move);
         if (cmd == CMD_LOOKUP || cmd == CMD_STORE) table_words++;
      end

      // Drain, let a trailing store finish, then give the verdict.
      wait_for_answers();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("hashed_transposition_table regression: pass");
      end else begin
         $display("hashed_transposition_table regression: fail");
      end
      $finish;
   end

endmodule
